### rtl/sbte_pkg.sv
// Package for the SPI buffered transfer engine.
// Holds item codes, controller states, the command struct and default sizes.
// No dependencies.
package sbte_pkg;

   localparam int DEFAULT_BUFFER_DEPTH = 32;
   localparam int DEFAULT_NUM_SELECTS  = 8;

   // Fixed field widths of one beat.
   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 5;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 8;
   localparam int PIN_W   = 3;

   // Width used for the count / index compares (holds 0..255 and a depth of 255).
   localparam int CMP_W = 9;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE    = 2'd0,
      FUNC_START    = 2'd1,
      FUNC_EXCHANGE = 2'd2,
      FUNC_READ     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;   // latch the incoming beat
      logic execute;   // apply the latched item to the buffer and state
   } cmd_type;

endpackage

### rtl/sbte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sbte_datapath.sv
// Datapath of the SPI buffered transfer engine: latched beat, transfer state,
// per-entry valid bits and the buffer RAM. Depends on sbte_pkg and sbte_ram.
module sbte_datapath import sbte_pkg::*; #(
   parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH,
   parameter int NUM_SELECTS  = DEFAULT_NUM_SELECTS
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [INDEX_W-1:0] req_index,
   input  logic [BYTE_W-1:0]  req_data,
   input  logic [COUNT_W-1:0] req_send_count,
   input  logic [COUNT_W-1:0] req_recv_count,
   input  logic               req_use_select,
   input  logic [PIN_W-1:0]   req_slave_pin,
   output logic [BYTE_W-1:0]  rsp_mosi_byte,
   output logic               rsp_mosi_valid,
   output logic               rsp_select_active,
   output logic [PIN_W-1:0]   rsp_selected_slave,
   output logic               rsp_busy_res,
   output logic               rsp_done_res,
   output logic [BYTE_W-1:0]  rsp_read_data,
   output logic               rsp_read_valid,
   output logic               rsp_rejected
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int LW = $clog2(BUFFER_DEPTH + 1);

   // latched beat
   func_type           func_ff;
   logic [INDEX_W-1:0] index_ff;
   logic [BYTE_W-1:0]  data_ff;
   logic [COUNT_W-1:0] scount_ff;
   logic [COUNT_W-1:0] rcount_ff;
   logic               use_sel_ff;
   logic [PIN_W-1:0]   pin_ff;

   // transfer state
   logic [LW-1:0]      length_ff, length_in;
   logic [LW-1:0]      pos_ff, pos_in;
   logic               busy_ff, busy_in;
   logic               sel_en_ff, sel_en_in;
   logic [PIN_W-1:0]   sel_idx_ff, sel_idx_in;
   logic               valid_ff [BUFFER_DEPTH];
   logic               valid_in [BUFFER_DEPTH];

   // result flags
   logic               mosi_v_ff, mosi_v_in;
   logic               done_ff, done_in;
   logic               rd_v_ff, rd_v_in;
   logic               rej_ff, rej_in;
   logic [AW-1:0]      raddr_ff;

   // RAM access
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [BYTE_W-1:0]  ram_rdata;

   logic [LW-1:0]      s_len, r_len, pos_next;
   logic               hit;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= func_type'(req_func);
         index_ff   <= req_index;
         data_ff    <= req_data;
         scount_ff  <= req_send_count;
         rcount_ff  <= req_recv_count;
         use_sel_ff <= req_use_select;
         pin_ff     <= req_slave_pin;
      end
   end

   assign s_len = (CMP_W'(scount_ff) > CMP_W'(BUFFER_DEPTH)) ? LW'(BUFFER_DEPTH)
                                                             : LW'(scount_ff);
   assign r_len = (CMP_W'(rcount_ff) > CMP_W'(BUFFER_DEPTH)) ? LW'(BUFFER_DEPTH)
                                                             : LW'(rcount_ff);
   assign pos_next = LW'(pos_ff + LW'(1));

   always_comb begin
      length_in  = length_ff;
      pos_in     = pos_ff;
      busy_in    = busy_ff;
      sel_en_in  = sel_en_ff;
      sel_idx_in = sel_idx_ff;
      valid_in   = valid_ff;
      mosi_v_in  = 1'b0;
      done_in    = 1'b0;
      rd_v_in    = 1'b0;
      rej_in     = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = '0;
      ram_re     = 1'b0;
      ram_raddr  = '0;
      unique case (func_ff)
         FUNC_WRITE: begin
            if (busy_ff) begin
               rej_in = 1'b1;
            end else if (CMP_W'(index_ff) < CMP_W'(BUFFER_DEPTH)) begin
               ram_we    = 1'b1;
               ram_waddr = AW'(index_ff);
               valid_in[AW'(index_ff)] = 1'b1;
            end
         end
         FUNC_START: begin
            if (busy_ff) begin
               rej_in = 1'b1;
            end else begin
               length_in = (s_len > r_len) ? s_len : r_len;
               // bytes between send and receive counts go out as zero
               for (int i = 0; i < BUFFER_DEPTH; i++) begin
                  if (CMP_W'(i) >= CMP_W'(s_len) && CMP_W'(i) < CMP_W'(r_len)) begin
                     valid_in[i] = 1'b0;
                  end
               end
               sel_en_in  = use_sel_ff && (CMP_W'(pin_ff) < CMP_W'(NUM_SELECTS));
               sel_idx_in = pin_ff;
               pos_in     = '0;
               busy_in    = 1'b1;
               ram_re     = 1'b1;
               ram_raddr  = '0;
               mosi_v_in  = 1'b1;
            end
         end
         FUNC_EXCHANGE: begin
            if (busy_ff) begin
               ram_we    = 1'b1;
               ram_waddr = AW'(pos_ff);
               valid_in[AW'(pos_ff)] = 1'b1;
               if (pos_next < length_ff) begin
                  pos_in    = pos_next;
                  ram_re    = 1'b1;
                  ram_raddr = AW'(pos_next);
                  mosi_v_in = 1'b1;
               end else begin
                  pos_in  = '0;
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
         end
         FUNC_READ: begin
            if (!busy_ff && CMP_W'(index_ff) < CMP_W'(length_ff)
                && CMP_W'(index_ff) < CMP_W'(BUFFER_DEPTH)) begin
               ram_re    = 1'b1;
               ram_raddr = AW'(index_ff);
               rd_v_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff  <= '0;
         pos_ff     <= '0;
         busy_ff    <= 1'b0;
         sel_en_ff  <= 1'b0;
         sel_idx_ff <= '0;
         mosi_v_ff  <= 1'b0;
         done_ff    <= 1'b0;
         rd_v_ff    <= 1'b0;
         rej_ff     <= 1'b0;
         raddr_ff   <= '0;
         for (int i = 0; i < BUFFER_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (cmd.execute) begin
         length_ff  <= length_in;
         pos_ff     <= pos_in;
         busy_ff    <= busy_in;
         sel_en_ff  <= sel_en_in;
         sel_idx_ff <= sel_idx_in;
         mosi_v_ff  <= mosi_v_in;
         done_ff    <= done_in;
         rd_v_ff    <= rd_v_in;
         rej_ff     <= rej_in;
         raddr_ff   <= ram_raddr;
         valid_ff   <= valid_in;
      end
   end

   sbte_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.execute && ram_we),
      .wr_addr (ram_waddr),
      .wr_data (data_ff),
      .rd_en   (cmd.execute && ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // never-written entries read as zero
   assign hit = valid_ff[raddr_ff];

   assign rsp_mosi_byte      = (mosi_v_ff && hit) ? ram_rdata : '0;
   assign rsp_mosi_valid     = mosi_v_ff;
   assign rsp_select_active  = busy_ff && sel_en_ff;
   assign rsp_selected_slave = sel_idx_ff;
   assign rsp_busy_res       = busy_ff;
   assign rsp_done_res       = done_ff;
   assign rsp_read_data      = (rd_v_ff && hit) ? ram_rdata : '0;
   assign rsp_read_valid     = rd_v_ff;
   assign rsp_rejected       = rej_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("done flagged while transfer still busy");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff < length_ff) || (pos_ff == '0))
      else $error("transfer position beyond length");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rej_ff |-> !mosi_v_ff && !done_ff && !rd_v_ff)
      else $error("rejected item produced data");

   a_read_idle: assert property (@(posedge clock) disable iff (reset)
      rd_v_ff |-> !busy_ff && !mosi_v_ff)
      else $error("read returned data during a transfer");

endmodule

### rtl/sbte_ctrl.sv
// Controller of the SPI buffered transfer engine: accept, execute, respond.
// Depends on sbte_pkg.
module sbte_ctrl import sbte_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EXEC: cmd.execute = 1'b1;
         ST_RESP: rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   a_exec_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.execute)
      else $error("accepted beat not executed");

   a_result_after_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid && req_stall)
      else $error("no result after execute");

   a_stall_while_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall && !cmd.capture)
      else $error("request accepted while a response is pending");

endmodule

### rtl/spi_buffered_transfer_engine.sv
// SPI buffered transfer engine, top level: controller plus datapath.
// Depends on sbte_pkg, sbte_ctrl, sbte_datapath (and sbte_ram beneath it).
//
// Byte-level SPI master transaction engine around one shared send/receive
// buffer of BUFFER_DEPTH bytes. Every request beat (func = write, start,
// byte exchanged, read) gives exactly one response beat. Writes load buffer
// bytes while idle; start clamps both counts to the depth, takes the larger
// as transfer length, zeroes bytes from the send count up to the receive
// count and offers byte 0 in rsp_mosi_byte with rsp_mosi_valid. Each
// byte-exchanged beat stores req_data in place and offers the next byte; the
// last one drops busy and select and pulses rsp_done_res. A zero length still
// exchanges one byte. Write or start while busy is flagged in rsp_rejected.
// Reads return bytes below the transfer length while idle.
// Each beat passes the accept state, an execute state that does the buffer
// RAM write and issues its read, and a response state that presents the
// registered RAM read port's data until the response is taken. Beats are
// handled one at a time. The buffer reads as all zeros after reset through
// per-entry valid bits that reset clears all together; there is no clearing
// pass. The range zeroing at start also clears its valid bits all together.
module spi_buffered_transfer_engine import sbte_pkg::*; #(
   parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH,
   parameter int NUM_SELECTS  = DEFAULT_NUM_SELECTS
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [INDEX_W-1:0] req_index,
   input  logic [BYTE_W-1:0]  req_data,
   input  logic [COUNT_W-1:0] req_send_count,
   input  logic [COUNT_W-1:0] req_recv_count,
   input  logic               req_use_select,
   input  logic [PIN_W-1:0]   req_slave_pin,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_mosi_byte,
   output logic               rsp_mosi_valid,
   output logic               rsp_select_active,
   output logic [PIN_W-1:0]   rsp_selected_slave,
   output logic               rsp_busy_res,
   output logic               rsp_done_res,
   output logic [BYTE_W-1:0]  rsp_read_data,
   output logic               rsp_read_valid,
   output logic               rsp_rejected
);

   cmd_type cmd;

   // sequencing: idle -> execute -> hold response until taken
   sbte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // buffer, transfer state and response fields; the fields stay stable
   // while the response is stalled since nothing executes in that state
   sbte_datapath #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .NUM_SELECTS  (NUM_SELECTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_func           (req_func),
      .req_index          (req_index),
      .req_data           (req_data),
      .req_send_count     (req_send_count),
      .req_recv_count     (req_recv_count),
      .req_use_select     (req_use_select),
      .req_slave_pin      (req_slave_pin),
      .rsp_mosi_byte      (rsp_mosi_byte),
      .rsp_mosi_valid     (rsp_mosi_valid),
      .rsp_select_active  (rsp_select_active),
      .rsp_selected_slave (rsp_selected_slave),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_read_data      (rsp_read_data),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_rejected       (rsp_rejected)
   );

endmodule
